[sv/hsm_pkg.sv]
// Shared constants, request codes and a helper for the hash set membership core.
package hsm_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_BUCKETS = 16;
  localparam int KEY_WIDTH   = 32;

  localparam int CFG_W  = 5;
  localparam int MIN_BUCKETS = 3;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
  localparam int HASH_W = $clog2(MAX_BUCKETS);
  localparam int SH_W   = $clog2(KEY_WIDTH);

  localparam logic [CFG_W-1:0] BUCKET_CFG_RESET = CFG_W'(MIN_BUCKETS);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Clamp a configured bucket count to the supported range.
  function automatic logic [NB_W-1:0] clamp_buckets(input logic [CFG_W-1:0] v);
    logic [NB_W-1:0] r;
    if (32'(v) < MIN_BUCKETS) begin
      r = NB_W'(MIN_BUCKETS);
    end else if (32'(v) > MAX_BUCKETS) begin
      r = NB_W'(MAX_BUCKETS);
    end else begin
      r = NB_W'(v);
    end
    return r;
  endfunction

endpackage

[sv/hsm_req_if.sv]
// Request channel: valid/ready handshake carrying one load or query item.
interface hsm_req_if import hsm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [KEY_WIDTH-1:0] key;
  logic                 last;

  modport source (output valid, req_type, key, last, input ready);
  modport sink   (input valid, req_type, key, last, output ready);
endinterface

[sv/hsm_rsp_if.sv]
// Response channel: valid/ready handshake carrying one query answer.
interface hsm_rsp_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

[sv/hsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hsm_mod.sv]
// Bit-serial restoring modulo unit: key mod bucket count, one key bit per cycle.
module hsm_mod import hsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] dividend,
  input  logic [NB_W-1:0]      divisor,
  output logic                 done,
  output logic [HASH_W-1:0]    rem
);

  logic                 busy;
  logic [SH_W-1:0]      cnt;
  logic [KEY_WIDTH-1:0] dvd;
  logic [HASH_W:0]      dsr;
  logic [HASH_W:0]      trial;
  logic [HASH_W-1:0]    step;

  // Shift in the next dividend bit, subtract the divisor when it fits.
  always_comb begin
    trial = {rem, dvd[KEY_WIDTH-1]};
    if (trial >= dsr) begin
      step = HASH_W'(trial - dsr);
    end else begin
      step = HASH_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= SH_W'(KEY_WIDTH - 1);
      dvd <= dividend;
      dsr <= (HASH_W + 1)'(divisor);
      rem <= '0;
    end else if (busy) begin
      rem <= step;
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

[sv/static_hash_set_membership_core.sv]
// Top level: static bucketed hash set with iterative build and lookup.
//
// Load items (req_type 0) append keys to a raw store of CAPACITY entries;
// keys beyond that are dropped. A load marked last builds the set: every
// stored key is hashed as key mod the bucket count (bucket_cfg, clamped to
// 3..MAX_BUCKETS and latched at the build), then the keys are copied into
// the placed store bucket by bucket, in load order within a bucket, while
// each bucket's start offset is recorded. Query items (req_type 1) hash the
// key and compare it against the placed keys of its bucket only; each query
// returns one found item, loads return nothing. Queries see the last
// finished build; after reset the set is empty.
// All hashing runs through one bit-serial modulo unit, shared by builds and
// queries. A query walks the keys of its bucket one compare at a time,
// reading the placed-key memory one entry per compare. A load without last
// leaves the sequencer idle, ready for the next item. The build after a
// last load hashes every stored key, then scans the raw store once per
// bucket. The request side is ready only while the sequencer is idle;
// a finished answer waits in its output register, so the next item can be
// accepted before the answer is taken.
module static_hash_set_membership_core import hsm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             bucket_cfg_we,
  input  logic [CFG_W-1:0] bucket_cfg_wdata,
  hsm_req_if.sink          req_ch,
  hsm_rsp_if.source        rsp_ch
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_QMOD   = 15'b000000000000010,
    S_QWAIT  = 15'b000000000000100,
    S_QRD0   = 15'b000000000001000,
    S_QRD1   = 15'b000000000010000,
    S_QRD2   = 15'b000000000100000,
    S_QSCAN  = 15'b000000001000000,
    S_QCMP   = 15'b000000010000000,
    S_QDONE  = 15'b000000100000000,
    S_BRD    = 15'b000001000000000,
    S_BLOAD  = 15'b000010000000000,
    S_BWAIT  = 15'b000100000000000,
    S_BSTART = 15'b001000000000000,
    S_BSRD   = 15'b010000000000000,
    S_BSCHK  = 15'b100000000000000
  } state_t;

  state_t state;

  // Configuration and build results.
  logic [CFG_W-1:0]     bucket_cfg;
  logic [NB_W-1:0]      built_nb;
  logic [CNT_W-1:0]     built_count;
  logic [CNT_W-1:0]     raw_count;

  // Build sequencer counters.
  logic [NB_W-1:0]      nb_build;
  logic [CNT_W-1:0]     bi;
  logic [CNT_W-1:0]     pos;
  logic [NB_W-1:0]      bb;

  // Query registers.
  logic [KEY_WIDTH-1:0] key_reg;
  logic [NB_W-1:0]      bkt;
  logic [CNT_W-1:0]     qidx;
  logic [CNT_W-1:0]     qend;
  logic                 hit;

  // Output register.
  logic                 rsp_valid;
  logic                 found;

  // Memory ports.
  logic                 raw_we;
  logic [KEY_WIDTH-1:0] raw_rdata;
  logic                 hash_we;
  logic [HASH_W-1:0]    hash_rdata;
  logic                 start_we;
  logic [NB_W-1:0]      start_raddr;
  logic [CNT_W-1:0]     start_rdata;
  logic                 placed_we;
  logic [KEY_WIDTH-1:0] placed_rdata;

  // Modulo unit ports.
  logic                 mod_start;
  logic [KEY_WIDTH-1:0] mod_dividend;
  logic [NB_W-1:0]      mod_divisor;
  logic                 mod_done;
  logic [HASH_W-1:0]    mod_rem;

  logic                 req_acc;
  logic                 rsp_free;

  assign req_ch.ready = (state == S_IDLE);
  assign req_acc      = req_ch.valid && req_ch.ready;
  assign rsp_ch.valid = rsp_valid;
  assign rsp_ch.found = found;
  assign rsp_free     = !rsp_valid || rsp_ch.ready;

  // Store a load key only while the raw store has room.
  assign raw_we    = req_acc && (req_ch.req_type == REQ_LOAD) &&
                     (raw_count < CNT_W'(CAPACITY));
  assign hash_we   = (state == S_BWAIT) && mod_done;
  assign start_we  = (state == S_BSTART);
  assign placed_we = (state == S_BSCHK) && (NB_W'(hash_rdata) == bb);

  // Read the bucket's start first, then the start of the following bucket.
  assign start_raddr = (state == S_QRD1) ? (bkt + 1'b1) : bkt;

  // Share the modulo unit between build hashing and query hashing.
  assign mod_start    = (state == S_QMOD) || (state == S_BLOAD);
  assign mod_dividend = (state == S_BLOAD) ? raw_rdata : key_reg;
  assign mod_divisor  = (state == S_BLOAD) ? nb_build : built_nb;

  hsm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_count[IDX_W-1:0]),
    .wdata (req_ch.key),
    .raddr (bi[IDX_W-1:0]),
    .rdata (raw_rdata)
  );

  hsm_ram #(.WIDTH(HASH_W), .DEPTH(CAPACITY)) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (bi[IDX_W-1:0]),
    .wdata (mod_rem),
    .raddr (bi[IDX_W-1:0]),
    .rdata (hash_rdata)
  );

  hsm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS + 1)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (bb),
    .wdata (pos),
    .raddr (start_raddr),
    .rdata (start_rdata)
  );

  hsm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_placed_ram (
    .clk   (clk),
    .we    (placed_we),
    .waddr (pos[IDX_W-1:0]),
    .wdata (raw_rdata),
    .raddr (qidx[IDX_W-1:0]),
    .rdata (placed_rdata)
  );

  hsm_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_cfg <= BUCKET_CFG_RESET;
    end else if (bucket_cfg_we) begin
      bucket_cfg <= bucket_cfg_wdata;
    end
  end

  // Output register: load when a query finishes, drop on handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_QDONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ch.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_QDONE && rsp_free) begin
      found <= hit;
    end
  end

  // Sequencer and its control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      raw_count   <= '0;
      built_count <= '0;
      built_nb    <= NB_W'(MIN_BUCKETS);
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req_ch.req_type == REQ_QUERY) begin
              state <= S_QMOD;
            end else begin
              if (raw_we) begin
                raw_count <= raw_count + 1'b1;
              end
              if (req_ch.last) begin
                state <= S_BRD;
              end
            end
          end
        end
        S_QMOD:  state <= S_QWAIT;
        S_QWAIT: begin
          if (mod_done) begin
            state <= S_QRD0;
          end
        end
        S_QRD0:  state <= S_QRD1;
        S_QRD1:  state <= S_QRD2;
        S_QRD2:  state <= S_QSCAN;
        S_QSCAN: begin
          if (qidx < qend) begin
            state <= S_QCMP;
          end else begin
            state <= S_QDONE;
          end
        end
        S_QCMP: begin
          if (placed_rdata == key_reg) begin
            state <= S_QDONE;
          end else begin
            state <= S_QSCAN;
          end
        end
        S_QDONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        S_BRD:   state <= S_BLOAD;
        S_BLOAD: state <= S_BWAIT;
        S_BWAIT: begin
          if (mod_done) begin
            if (bi + 1'b1 == raw_count) begin
              state <= S_BSTART;
            end else begin
              state <= S_BRD;
            end
          end
        end
        S_BSTART: begin
          if (bb == nb_build) begin
            // Commit the new set and empty the raw store.
            built_count <= raw_count;
            built_nb    <= nb_build;
            raw_count   <= '0;
            state       <= S_IDLE;
          end else begin
            state <= S_BSRD;
          end
        end
        S_BSRD:  state <= S_BSCHK;
        S_BSCHK: begin
          if (bi + 1'b1 == raw_count) begin
            state <= S_BSTART;
          end else begin
            state <= S_BSRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          key_reg  <= req_ch.key;
          nb_build <= clamp_buckets(bucket_cfg);
          bi       <= '0;
          bb       <= '0;
          pos      <= '0;
        end
      end
      S_QWAIT: begin
        if (mod_done) begin
          bkt <= NB_W'(mod_rem);
        end
      end
      S_QRD1: begin
        // Before the first build the bucket offsets hold nothing: walk no key.
        if (built_count == '0) begin
          qidx <= '0;
        end else begin
          qidx <= start_rdata;
        end
      end
      S_QRD2: begin
        // Never walk past the keys of the last build.
        if (built_count == '0 || start_rdata > built_count) begin
          qend <= built_count;
        end else begin
          qend <= start_rdata;
        end
      end
      S_QSCAN: begin
        if (qidx >= qend) begin
          hit <= 1'b0;
        end
      end
      S_QCMP: begin
        if (placed_rdata == key_reg) begin
          hit <= 1'b1;
        end else begin
          qidx <= qidx + 1'b1;
        end
      end
      S_BWAIT: begin
        if (mod_done) begin
          if (bi + 1'b1 == raw_count) begin
            bi <= '0;
          end else begin
            bi <= bi + 1'b1;
          end
        end
      end
      S_BSCHK: begin
        if (placed_we) begin
          pos <= pos + 1'b1;
        end
        if (bi + 1'b1 == raw_count) begin
          bi <= '0;
          bb <= bb + 1'b1;
        end else begin
          bi <= bi + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[test/static_hash_set_membership_core_tb.sv]
// Testbench for the static hash set membership core: loads, builds and queries.
`timescale 1ns / 1ps

module static_hash_set_membership_core_tb import hsm_pkg::*; ();

  // Longest build: every stored key hashed, then each bucket scanned over the raw store.
  localparam int BUILD_WAIT     = CAPACITY * (KEY_WIDTH + 4)
                                  + MAX_BUCKETS * (2 * CAPACITY + 1) + 64;
  // Long response hold-off, so the answer register fills and the request side stalls.
  localparam int STALL_CYCLES   = 400;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 8 * BUILD_WAIT + 2 * STALL_CYCLES;

  logic             clk;
  logic             rst;
  logic             bucket_cfg_we;
  logic [CFG_W-1:0] bucket_cfg_wdata;

  hsm_req_if req_ch ();
  hsm_rsp_if rsp_ch ();

  static_hash_set_membership_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .bucket_cfg_we    (bucket_cfg_we),
    .bucket_cfg_wdata (bucket_cfg_wdata),
    .req_ch           (req_ch),
    .rsp_ch           (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: keys gathered since the last build, the built set laid
  // out bucket by bucket, and the bucket count in the register and at build.
  // ---------------------------------------------------------------------------
  logic [KEY_WIDTH-1:0] pend_keys[$];
  logic [KEY_WIDTH-1:0] set_keys[CAPACITY];
  int unsigned          bucket_base[MAX_BUCKETS+1] = '{default: 0};
  int unsigned          set_size = 0;
  int unsigned          set_nb = MIN_BUCKETS;
  logic [CFG_W-1:0]     nb_setting = BUCKET_CFG_RESET;

  // Answers still owed by the block, oldest first.
  bit                   pending_found[$];

  int                   errors = 0;
  int                   items_sent = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          rcv_idle_pct = 0;
  int                   send_calm = 0;
  bit                   stall_request = 1'b0;
  // A last load was taken and no query has been taken since: a build may run.
  bit                   build_running = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Map a register value to the bucket count actually used: out-of-range values
  // snap to the nearest supported count.
  function automatic int unsigned clamped_buckets(input logic [CFG_W-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n < MIN_BUCKETS) n = MIN_BUCKETS;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    return n;
  endfunction

  // Rebuild the set from the gathered keys: count per bucket, form start
  // offsets, then place keys bucket by bucket in arrival order.
  function automatic void rebuild_set();
    int unsigned tally[MAX_BUCKETS+1];
    int unsigned slot[MAX_BUCKETS+1];
    int unsigned nb;
    int unsigned acc;
    int unsigned b;
    nb  = clamped_buckets(nb_setting);
    acc = 0;
    for (int i = 0; i <= MAX_BUCKETS; i++) tally[i] = 0;
    foreach (pend_keys[i]) tally[pend_keys[i] % nb]++;
    for (int i = 0; i <= MAX_BUCKETS; i++) begin
      bucket_base[i] = acc;
      slot[i]        = acc;
      if (i < nb) acc += tally[i];
    end
    foreach (pend_keys[i]) begin
      b = pend_keys[i] % nb;
      set_keys[slot[b]] = pend_keys[i];
      slot[b]++;
    end
    set_size = pend_keys.size();
    set_nb   = nb;
    pend_keys.delete();
  endfunction

  // Take one load: keep the key while there is room, drop it otherwise; a
  // last flag builds from whatever is held.
  function automatic void record_load(input logic [KEY_WIDTH-1:0] k, input logic lst);
    if (pend_keys.size() < CAPACITY) pend_keys.push_back(k);
    if (lst) rebuild_set();
  endfunction

  // Answer a query from the last finished build, searching its bucket only.
  function automatic bit lookup_found(input logic [KEY_WIDTH-1:0] k);
    int unsigned b;
    int unsigned stop;
    b    = k % set_nb;
    stop = bucket_base[b+1];
    if (stop > set_size) stop = set_size;
    for (int unsigned i = bucket_base[b]; i < stop; i++) begin
      if (set_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Key and setting generators
  // ---------------------------------------------------------------------------

  // Mix small keys, keys near the top of the range and fully random ones.
  function automatic logic [KEY_WIDTH-1:0] random_key();
    logic [KEY_WIDTH-1:0] k;
    case ($urandom_range(3))
      0:       k = KEY_WIDTH'($urandom_range(40));
      1:       k = '1 - KEY_WIDTH'($urandom_range(40));
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // Pick a query key: mostly keys offered in this set, some neighbors in the
  // same bucket (likely misses), some unrelated keys.
  function automatic logic [KEY_WIDTH-1:0] probe_key(input logic [KEY_WIDTH-1:0] pool[$]);
    logic [KEY_WIDTH-1:0] k;
    if (pool.size() == 0) return random_key();
    k = pool[$urandom_range(pool.size() - 1)];
    case ($urandom_range(3))
      2:       k = k + set_nb * $urandom_range(1, 4);
      3:       k = random_key();
      default: ;
    endcase
    return k;
  endfunction

  // Bucket count for the register: extremes and out-of-range values often.
  function automatic logic [CFG_W-1:0] pick_buckets();
    logic [CFG_W-1:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = '1;
      2:       v = CFG_W'(MAX_BUCKETS);
      3:       v = CFG_W'($urandom_range(2 ** CFG_W - 1));
      default: v = CFG_W'($urandom_range(MIN_BUCKETS, MAX_BUCKETS));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver, result check and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop ready at the configured rate, with quiet stretches; on a
  // stall request hold ready low for a long fixed count.
  initial begin
    int calm;
    calm = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      if (calm > 0) calm--;
      else if ($urandom_range(39) == 0) calm = $urandom_range(10, 60);
      rsp_ch.ready <= (calm > 0) || ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Compare each accepted answer with the oldest prediction.
  always @(posedge clk) begin
    bit want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_found.size() == 0) begin
        $error("found: no answer expected, actual %0b", rsp_ch.found);
        errors++;
      end else begin
        want = pending_found.pop_front();
        if (rsp_ch.found !== want) begin
          $error("found: expected %0b, actual %0b", want, rsp_ch.found);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until taken; keep valid high on return so a
  // back-to-back item follows without a bubble.
  task automatic send_req(input logic kind, input logic [KEY_WIDTH-1:0] k, input logic lst);
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(39) == 0) send_calm = $urandom_range(10, 40);
    if (send_calm == 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.key      <= k;
    req_ch.last     <= lst;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (kind == REQ_QUERY) begin
      // A taken query means the sequencer was idle, so any build has finished.
      pending_found.push_back(lookup_found(k));
      build_running = 1'b0;
    end else begin
      record_load(k, lst);
      if (lst) build_running = 1'b1;
    end
  endtask

  // Withdraw the request and wait for every owed answer.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_found.size() != 0);
  endtask

  // Write the bucket count while the block is idle; a build answers nothing,
  // so wait out its full length if one may still be running.
  task automatic set_buckets(input logic [CFG_W-1:0] v);
    drain_results();
    if (build_running) repeat (BUILD_WAIT) @(posedge clk);
    else repeat (4) @(posedge clk);
    build_running = 1'b0;
    bucket_cfg_we    <= 1'b1;
    bucket_cfg_wdata <= v;
    @(posedge clk);
    bucket_cfg_we <= 1'b0;
    nb_setting = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Query before any build: the set is empty.
  task automatic test_empty_set();
    send_req(REQ_QUERY, '0, 1'b0);
    send_req(REQ_QUERY, '1, 1'b1);
  endtask

  // Build with the reset bucket count: key extremes and a duplicate all land
  // in bucket 0, leaving the other buckets empty.
  task automatic test_basic_build();
    send_req(REQ_LOAD, '0, 1'b0);
    send_req(REQ_LOAD, '1, 1'b0);
    send_req(REQ_LOAD, KEY_WIDTH'(3), 1'b0);
    send_req(REQ_LOAD, KEY_WIDTH'(3), 1'b0);
    send_req(REQ_LOAD, KEY_WIDTH'(6), 1'b1);
    send_req(REQ_QUERY, '0, 1'b0);
    send_req(REQ_QUERY, '1, 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(3), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(6), 1'b1);
    send_req(REQ_QUERY, KEY_WIDTH'(9), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(1), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(2), 1'b0);
  endtask

  // Queries while a load is open see the previous build; the new build
  // replaces it completely.
  task automatic test_query_during_load();
    send_req(REQ_LOAD, KEY_WIDTH'(5), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(5), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(3), 1'b0);
    send_req(REQ_LOAD, KEY_WIDTH'(8), 1'b1);
    send_req(REQ_QUERY, KEY_WIDTH'(5), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(8), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(3), 1'b0);
  endtask

  // Changing the bucket count after a build leaves queries on the latched
  // count until the next build.
  task automatic test_latched_buckets();
    set_buckets(CFG_W'(MAX_BUCKETS));
    send_req(REQ_QUERY, KEY_WIDTH'(5), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(8), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(11), 1'b0);
    send_req(REQ_LOAD, KEY_WIDTH'(21), 1'b1);
    send_req(REQ_QUERY, KEY_WIDTH'(21), 1'b0);
    send_req(REQ_QUERY, KEY_WIDTH'(5), 1'b0);
  endtask

  // Small builds at each extreme of the register, out-of-range values too.
  task automatic test_bucket_extremes();
    logic [CFG_W-1:0]     sweep[7] = '{'0, CFG_W'(1), CFG_W'(2), CFG_W'(17), '1,
                                       CFG_W'(MAX_BUCKETS), CFG_W'(MIN_BUCKETS)};
    logic [KEY_WIDTH-1:0] pool[$];
    foreach (sweep[s]) begin
      set_buckets(sweep[s]);
      pool.delete();
      for (int i = 0; i < 3; i++) begin
        pool.push_back(random_key());
        send_req(REQ_LOAD, pool[$], i == 2);
      end
      repeat (5) send_req(REQ_QUERY, probe_key(pool), 1'($urandom_range(1)));
    end
  endtask

  // Overfill the raw store: extra keys drop, and a last flag on a dropped
  // key still builds from the stored ones.
  task automatic test_store_full();
    logic [KEY_WIDTH-1:0] pool[$];
    int                   n;
    repeat (3) begin
      set_buckets(pick_buckets());
      pool.delete();
      n = CAPACITY + $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        pool.push_back(random_key());
        send_req(REQ_LOAD, pool[$], i == n - 1);
      end
      foreach (pool[i]) send_req(REQ_QUERY, pool[i], 1'($urandom_range(1)));
    end
  endtask

  // Hold the receiver off while queries keep coming, so the answer register
  // fills and the request side stalls; then pause until all answers are in.
  task automatic test_backpressure();
    logic [KEY_WIDTH-1:0] pool[$];
    for (int i = 0; i < 6; i++) begin
      pool.push_back(random_key());
      send_req(REQ_LOAD, pool[$], i == 5);
    end
    stall_request = 1'b1;
    repeat (16) send_req(REQ_QUERY, probe_key(pool), 1'b0);
    drain_results();
  endtask

  // One well-formed load/build/query sequence with random content and some
  // noise: queries mixed into the load, sets left open, duplicates, same-bucket
  // clusters, overfills, and count changes after the build.
  task automatic run_random_set();
    logic [KEY_WIDTH-1:0] pool[$];
    logic [KEY_WIDTH-1:0] k;
    int                   n_loads;
    int unsigned          stride;
    bit                   keep_open;
    if ($urandom_range(1) == 0) set_buckets(pick_buckets());
    n_loads   = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                         : $urandom_range(1, 10);
    keep_open = ($urandom_range(7) == 0);
    stride    = clamped_buckets(nb_setting) * $urandom_range(1, 3);
    for (int i = 0; i < n_loads; i++) begin
      case ($urandom_range(4))
        0:       k = (pool.size() != 0) ? pool[$urandom_range(pool.size() - 1)] : random_key();
        1:       k = (pool.size() != 0) ? pool[$] + stride : random_key();
        default: k = random_key();
      endcase
      if ($urandom_range(5) == 0) begin
        send_req(REQ_QUERY, probe_key(pool), 1'($urandom_range(1)));
      end
      pool.push_back(k);
      send_req(REQ_LOAD, k, (i == n_loads - 1) && !keep_open);
    end
    repeat ($urandom_range(4, 20)) send_req(REQ_QUERY, probe_key(pool), 1'($urandom_range(1)));
    if ($urandom_range(5) == 0) begin
      set_buckets(pick_buckets());
      repeat ($urandom_range(2, 6)) begin
        send_req(REQ_QUERY, probe_key(pool), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_sets(input int target);
    int goal;
    goal = items_sent + target;
    while (items_sent < goal) run_random_set();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst              <= 1'b1;
    bucket_cfg_we    <= 1'b0;
    bucket_cfg_wdata <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_LOAD;
    req_ch.key       <= '0;
    req_ch.last      <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 29;
    rcv_idle_pct  = 68;
    test_empty_set();
    test_basic_build();
    test_query_during_load();
    test_latched_buckets();
    test_bucket_extremes();
    test_random_sets(530);

    // Swap the idle rates.
    send_idle_pct = 68;
    rcv_idle_pct  = 29;
    test_store_full();
    test_random_sets(530);

    // No idling on either side.
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    test_backpressure();
    test_random_sets(530);

    // Collect the last answers, then watch for strays over one build length.
    drain_results();
    repeat (BUILD_WAIT) @(posedge clk);
    if (pending_found.size() != 0) begin
      $error("found: %0d expected answers never arrived", pending_found.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
